[hw/rtl/pinr_pkg.sv]
// ============================================================================
// pinr_pkg
// Shared types, register indexes and fixed-point helpers of the pinhole
// reprojection residual datapath.
// ============================================================================
package pinr_pkg;

    typedef logic signed [31:0] s32_t;
    typedef logic signed [35:0] s36_t;
    typedef logic signed [34:0] s35_t;
    typedef logic signed [63:0] s64_t;

    // Configuration register indexes
    localparam logic [2:0] REG_K1 = 3'd0;
    localparam logic [2:0] REG_K2 = 3'd1;
    localparam logic [2:0] REG_P1 = 3'd2;
    localparam logic [2:0] REG_P2 = 3'd3;
    localparam logic [2:0] REG_FX = 3'd4;
    localparam logic [2:0] REG_FY = 3'd5;
    localparam logic [2:0] REG_CX = 3'd6;
    localparam logic [2:0] REG_CY = 3'd7;

    localparam s64_t S32_MAX  = 64'sd2147483647;
    localparam s64_t S32_MIN  = -64'sd2147483648;
    localparam s64_t ONE_Q28  = 64'sd268435456;
    localparam s32_t ONE_Q30  = 32'sd1073741824;
    localparam s64_t HALF_Q28 = 64'sd134217728;
    localparam s64_t HALF_Q30 = 64'sd536870912;

    typedef struct packed {
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic signed [31:0] p1;
        logic signed [31:0] p2;
        logic [30:0]        fx;
        logic [30:0]        fy;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] obs_v;
        logic signed [31:0] obs_u;
    } obs_t;

    typedef struct packed {
        obs_t obs;
        logic dz;
    } tail_t;

    typedef struct packed {
        obs_t               obs;
        logic signed [31:0] tz;
        logic signed [31:0] ty;
        logic signed [31:0] tx;
        logic signed [31:0] pz;
        logic signed [31:0] py;
        logic signed [31:0] px;
    } pose_side_t;

    // Round half up on a right shift by 28
    function automatic s64_t rnd28(input s64_t x);
        return (x + HALF_Q28) >>> 28;
    endfunction

    // Clamp to the signed 32-bit range
    function automatic s32_t sat32(input s64_t x);
        if (x > S32_MAX) begin
            return 32'sh7fffffff;
        end
        if (x < S32_MIN) begin
            return 32'sh80000000;
        end
        return $signed(x[31:0]);
    endfunction

endpackage

[hw/rtl/pinr_div.sv]
// ============================================================================
// pinr_div
// Pipelined restoring divider: one quotient bit per stage, several lanes
// sharing one divisor, with an overflow flag and a sideband that travels along.
// ============================================================================
module pinr_div #(
    parameter int LANES = 2,
    parameter int NW    = 63,
    parameter int DW    = 35,
    parameter int QB    = 32,
    parameter int SW    = 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [LANES-1:0][NW-1:0]   num,
    input  logic [DW-1:0]              den,
    input  logic [SW-1:0]              side,
    output logic                       out_valid,
    output logic [LANES-1:0][QB-1:0]   quo,
    output logic [LANES-1:0]           ovf,
    output logic [SW-1:0]              side_out
);

    localparam int CW = (NW > DW + QB) ? NW : DW + QB;

    logic [QB:0]                vld_reg;
    logic [LANES-1:0][NW-1:0]   rem_reg  [QB+1];
    logic [LANES-1:0][QB-1:0]   q_reg    [QB+1];
    logic [LANES-1:0]           ovf_reg  [QB+1];
    logic [DW-1:0]              den_reg  [QB+1];
    logic [SW-1:0]              side_reg [QB+1];
    logic [LANES-1:0][NW-1:0]   rem_next [QB];
    logic [LANES-1:0][QB-1:0]   q_next   [QB];
    logic [LANES-1:0]           ovf_next;
    logic [CW-1:0]              dsh      [QB];

    // Resolve one quotient bit per stage, most significant first
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            ovf_next[l] = CW'(num[l] >> QB) >= CW'(den);
        end
        for (int s = 0; s < QB; s++) begin
            dsh[s] = CW'(den_reg[s]) << (QB - 1 - s);
            for (int l = 0; l < LANES; l++) begin
                if (CW'(rem_reg[s][l]) >= dsh[s]) begin
                    rem_next[s][l] = NW'(CW'(rem_reg[s][l]) - dsh[s]);
                    q_next[s][l]   = q_reg[s][l] | (QB'(1) << (QB - 1 - s));
                end else begin
                    rem_next[s][l] = rem_reg[s][l];
                    q_next[s][l]   = q_reg[s][l];
                end
            end
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[QB-1:0], in_valid};
        end
    end

    // Payload stages
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= num;
            q_reg[0]    <= '0;
            ovf_reg[0]  <= ovf_next;
            den_reg[0]  <= den;
            side_reg[0] <= side;
            for (int s = 0; s < QB; s++) begin
                rem_reg[s+1]  <= rem_next[s];
                q_reg[s+1]    <= q_next[s];
                ovf_reg[s+1]  <= ovf_reg[s];
                den_reg[s+1]  <= den_reg[s];
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    assign out_valid = vld_reg[QB];
    assign quo       = q_reg[QB];
    assign ovf       = ovf_reg[QB];
    assign side_out  = side_reg[QB];

endmodule

[hw/rtl/pinr_rot.sv]
// ============================================================================
// pinr_rot
// Quaternion to rotation matrix: products, scaled entries and squared norm,
// then nine rounded divisions by the norm to signed Q2.30 entries.
// ============================================================================
module pinr_rot
    import pinr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic         in_valid,
    input  logic signed [15:0] qx,
    input  logic signed [15:0] qy,
    input  logic signed [15:0] qz,
    input  logic signed [15:0] qw,
    input  pose_side_t   side,
    output logic         out_valid,
    output s32_t         rot [9],
    output pose_side_t   side_out
);

    typedef struct packed {
        pose_side_t ps;
        logic [8:0] neg;
        logic       nzero;
    } rot_side_t;

    localparam int SW = $bits(rot_side_t);

    logic [1:0] vld_reg;
    logic       vld3_reg;
    s32_t xx_reg, yy_reg, zz_reg, ww_reg, xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    pose_side_t ps1_reg, ps2_reg;
    logic signed [33:0] m_next [9];
    logic signed [33:0] m_reg  [9];
    logic [32:0] n_next, n_reg;

    logic [8:0][62:0] dnum;
    logic [8:0]       dneg;
    logic [32:0]      dmag [9];
    rot_side_t        dside, dside_out;
    logic             dvalid;
    logic [8:0][30:0] dquo;
    logic [8:0]       dovf;
    s32_t             rot_next [9];
    s32_t             rot_reg  [9];
    pose_side_t       ps3_reg;

    // Scaled entries and squared norm
    always_comb begin
        m_next[0] = 34'(ww_reg) + 34'(xx_reg) - 34'(yy_reg) - 34'(zz_reg);
        m_next[1] = (34'(xy_reg) - 34'(wz_reg)) <<< 1;
        m_next[2] = (34'(xz_reg) + 34'(wy_reg)) <<< 1;
        m_next[3] = (34'(xy_reg) + 34'(wz_reg)) <<< 1;
        m_next[4] = 34'(ww_reg) - 34'(xx_reg) + 34'(yy_reg) - 34'(zz_reg);
        m_next[5] = (34'(yz_reg) - 34'(wx_reg)) <<< 1;
        m_next[6] = (34'(xz_reg) - 34'(wy_reg)) <<< 1;
        m_next[7] = (34'(yz_reg) + 34'(wx_reg)) <<< 1;
        m_next[8] = 34'(ww_reg) - 34'(xx_reg) - 34'(yy_reg) + 34'(zz_reg);
        n_next    = 33'(xx_reg) + 33'(yy_reg) + 33'(zz_reg) + 33'(ww_reg);
    end

    // Divider operands: magnitude times 2^30 plus half the norm
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            dneg[i] = m_reg[i][33];
            dmag[i] = m_reg[i][33] ? 33'(-m_reg[i]) : 33'(m_reg[i]);
            dnum[i] = {dmag[i], 30'd0} + 63'(n_reg >> 1);
        end
        dside.ps    = ps2_reg;
        dside.neg   = dneg;
        dside.nzero = (n_reg == '0);
    end

    pinr_div #(
        .LANES(9), .NW(63), .DW(33), .QB(31), .SW(SW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (vld_reg[1]),
        .num      (dnum),
        .den      (n_reg),
        .side     (dside),
        .out_valid(dvalid),
        .quo      (dquo),
        .ovf      (dovf),
        .side_out (dside_out)
    );

    // Apply signs; a zero quaternion gives the identity
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            if (dside_out.nzero) begin
                rot_next[i] = (i % 4 == 0) ? ONE_Q30 : 32'sd0;
            end else if (dside_out.neg[i]) begin
                rot_next[i] = -$signed({1'b0, dquo[i]});
            end else begin
                rot_next[i] = $signed({1'b0, dquo[i]});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            vld3_reg <= 1'b0;
        end else if (en) begin
            vld_reg  <= {vld_reg[0], in_valid};
            vld3_reg <= dvalid | (dovf[0] & 1'b0);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xx_reg  <= qx * qx;
            yy_reg  <= qy * qy;
            zz_reg  <= qz * qz;
            ww_reg  <= qw * qw;
            xy_reg  <= qx * qy;
            xz_reg  <= qx * qz;
            yz_reg  <= qy * qz;
            wx_reg  <= qw * qx;
            wy_reg  <= qw * qy;
            wz_reg  <= qw * qz;
            ps1_reg <= side;
            m_reg   <= m_next;
            n_reg   <= n_next;
            ps2_reg <= ps1_reg;
            rot_reg <= rot_next;
            ps3_reg <= dside_out.ps;
        end
    end

    assign out_valid = vld3_reg;
    assign rot       = rot_reg;
    assign side_out  = ps3_reg;

endmodule

[hw/rtl/pinr_proj.sv]
// ============================================================================
// pinr_proj
// Rotate and translate the world point, then divide by depth to normalized
// Q4.28 coordinates with saturation and a zero-depth flag.
// ============================================================================
module pinr_proj
    import pinr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic       in_valid,
    input  s32_t       rot [9],
    input  pose_side_t side,
    output logic       out_valid,
    output s32_t       u,
    output s32_t       v,
    output tail_t      tail
);

    typedef struct packed {
        tail_t tl;
        logic  negu;
        logic  negv;
    } proj_side_t;

    localparam int SW = $bits(proj_side_t);

    logic [2:0]  vld_reg;
    logic        vld4_reg;
    s32_t        pt [3];
    s32_t        tr [3];
    s64_t        prod_next [9];
    s64_t        prod_reg  [9];
    s64_t        acc_next  [3];
    s64_t        acc_reg   [3];
    s35_t        cam_next  [3];
    s35_t        cam_reg   [3];
    pose_side_t  ps1_reg, ps2_reg;
    obs_t        obs3_reg;

    logic [34:0]       mag [3];
    logic [1:0][62:0]  dnum;
    proj_side_t        dside, dside_out;
    logic              dvalid;
    logic [1:0][31:0]  dquo;
    logic [1:0]        dovf;
    s32_t              u_next, v_next, u_reg, v_reg;
    tail_t             tail_reg;

    // Rotation products
    always_comb begin
        pt[0] = side.px;
        pt[1] = side.py;
        pt[2] = side.pz;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                prod_next[i*3+j] = rot[i*3+j] * pt[j];
            end
        end
    end

    // Row sums, then round and translate
    always_comb begin
        tr[0] = ps2_reg.tx;
        tr[1] = ps2_reg.ty;
        tr[2] = ps2_reg.tz;
        for (int i = 0; i < 3; i++) begin
            acc_next[i] = prod_reg[i*3] + prod_reg[i*3+1] + prod_reg[i*3+2];
            cam_next[i] = 35'((acc_reg[i] + HALF_Q30) >>> 30) + 35'(tr[i]);
        end
    end

    // Divider operands: |X| * 2^28 + |Z|/2 over |Z|
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag[i] = cam_reg[i][34] ? 35'(-cam_reg[i]) : 35'(cam_reg[i]);
        end
        dnum[0]        = {mag[0], 28'd0} + 63'(mag[2] >> 1);
        dnum[1]        = {mag[1], 28'd0} + 63'(mag[2] >> 1);
        dside.tl.obs   = obs3_reg;
        dside.tl.dz    = (cam_reg[2] == '0);
        dside.negu     = cam_reg[0][34] ^ cam_reg[2][34];
        dside.negv     = cam_reg[1][34] ^ cam_reg[2][34];
    end

    pinr_div #(
        .LANES(2), .NW(63), .DW(35), .QB(32), .SW(SW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (vld_reg[2]),
        .num      (dnum),
        .den      (mag[2]),
        .side     (dside),
        .out_valid(dvalid),
        .quo      (dquo),
        .ovf      (dovf),
        .side_out (dside_out)
    );

    // Apply sign and clamp to 32 bits
    always_comb begin
        if (dside_out.negu) begin
            u_next = (dovf[0] || (dquo[0][31] && (dquo[0][30:0] != '0)))
                     ? 32'sh80000000 : -$signed(dquo[0]);
        end else begin
            u_next = (dovf[0] || dquo[0][31]) ? 32'sh7fffffff : $signed(dquo[0]);
        end
        if (dside_out.negv) begin
            v_next = (dovf[1] || (dquo[1][31] && (dquo[1][30:0] != '0)))
                     ? 32'sh80000000 : -$signed(dquo[1]);
        end else begin
            v_next = (dovf[1] || dquo[1][31]) ? 32'sh7fffffff : $signed(dquo[1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            vld4_reg <= 1'b0;
        end else if (en) begin
            vld_reg  <= {vld_reg[1:0], in_valid};
            vld4_reg <= dvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            ps1_reg  <= side;
            acc_reg  <= acc_next;
            ps2_reg  <= ps1_reg;
            cam_reg  <= cam_next;
            obs3_reg <= ps2_reg.obs;
            u_reg    <= u_next;
            v_reg    <= v_next;
            tail_reg <= dside_out.tl;
        end
    end

    assign out_valid = vld4_reg;
    assign u         = u_reg;
    assign v         = v_reg;
    assign tail      = tail_reg;

endmodule

[hw/rtl/pinr_dist.sv]
// ============================================================================
// pinr_dist
// Radial and tangential distortion, focal scaling, principal point and the
// saturated residual, as a twelve-stage multiply/round/clamp pipeline.
// ============================================================================
module pinr_dist
    import pinr_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  cfg_t  cfg,
    input  s32_t  u,
    input  s32_t  v,
    input  tail_t tail,
    output logic  out_valid,
    output s32_t  res_u,
    output s32_t  res_v,
    output logic  depth_zero
);

    localparam int NST = 12;

    logic [NST-1:0] vld_reg;
    tail_t sd_reg   [NST];
    s32_t  u_dly_reg [7];
    s32_t  v_dly_reg [7];

    s32_t k1, k2, p1, p2, fx, fy;

    s64_t puu_next, pvv_next, puv_next, puu_reg, pvv_reg, puv_reg;
    s32_t uu_next, vv_next, uv_next, uu_reg, vv_reg, uv_reg;
    s32_t rho2_next, rho2_reg, uu3_reg, vv3_reg, uv3_reg;
    s32_t bru_next, brv_next, bru_reg, brv_reg;
    s64_t prho4_next, pk1_next, pp1uv_next, pp2uv_next;
    s64_t prho4_reg, pk1_reg, pp1uv_reg, pp2uv_reg;
    s32_t rho4_next, rho4_reg;
    s36_t k1t_next, k1t_reg, k1t6_reg, tp1uv_next, tp2uv_next, tp1uv_reg, tp2uv_reg;
    s64_t pp2bu_next, pp1bv_next, pp2bu_reg, pp1bv_reg;
    s64_t pk2_next, pk2_reg;
    s32_t du_next, dv_next, du_reg, dv_reg, du7_reg, dv7_reg, du8_reg, dv8_reg;
    s32_t lr_next, lr_reg;
    s64_t plu_next, plv_next, plu_reg, plv_reg;
    s32_t ud_next, vd_next, ud_reg, vd_reg;
    s64_t pfu_next, pfv_next, pfu_reg, pfv_reg;
    s36_t pu_next, pv_next, pu_reg, pv_reg;
    s32_t resu_next, resv_next, resu_reg, resv_reg;

    assign k1 = cfg.k1;
    assign k2 = cfg.k2;
    assign p1 = cfg.p1;
    assign p2 = cfg.p2;
    assign fx = $signed({1'b0, cfg.fx});
    assign fy = $signed({1'b0, cfg.fy});

    // Stage datapath, one multiply or one round-and-clamp per stage
    always_comb begin
        puu_next   = u * u;
        pvv_next   = v * v;
        puv_next   = u * v;

        uu_next    = sat32(rnd28(puu_reg));
        vv_next    = sat32(rnd28(pvv_reg));
        uv_next    = sat32(rnd28(puv_reg));

        rho2_next  = sat32(64'(uu_reg) + 64'(vv_reg));

        bru_next   = sat32(64'(rho2_reg) + (64'(uu3_reg) <<< 1));
        brv_next   = sat32(64'(rho2_reg) + (64'(vv3_reg) <<< 1));
        prho4_next = rho2_reg * rho2_reg;
        pk1_next   = k1 * rho2_reg;
        pp1uv_next = p1 * uv3_reg;
        pp2uv_next = p2 * uv3_reg;

        rho4_next  = sat32(rnd28(prho4_reg));
        k1t_next   = 36'(rnd28(pk1_reg));
        tp1uv_next = 36'(rnd28(pp1uv_reg));
        tp2uv_next = 36'(rnd28(pp2uv_reg));
        pp2bu_next = p2 * bru_reg;
        pp1bv_next = p1 * brv_reg;

        pk2_next   = k2 * rho4_reg;
        du_next    = sat32((64'(tp1uv_reg) <<< 1) + rnd28(pp2bu_reg));
        dv_next    = sat32(rnd28(pp1bv_reg) + (64'(tp2uv_reg) <<< 1));

        lr_next    = sat32(ONE_Q28 + 64'(k1t6_reg) + rnd28(pk2_reg));

        plu_next   = lr_reg * u_dly_reg[6];
        plv_next   = lr_reg * v_dly_reg[6];

        ud_next    = sat32(rnd28(plu_reg) + 64'(du8_reg));
        vd_next    = sat32(rnd28(plv_reg) + 64'(dv8_reg));

        pfu_next   = fx * ud_reg;
        pfv_next   = fy * vd_reg;

        pu_next    = 36'(rnd28(pfu_reg)) + 36'(cfg.cx);
        pv_next    = 36'(rnd28(pfv_reg)) + 36'(cfg.cy);

        // Zero depth forces zero residuals
        if (sd_reg[10].dz) begin
            resu_next = '0;
            resv_next = '0;
        end else begin
            resu_next = sat32(64'(pu_reg) - 64'(sd_reg[10].obs.obs_u));
            resv_next = sat32(64'(pv_reg) - 64'(sd_reg[10].obs.obs_v));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sd_reg[0]    <= tail;
            for (int s = 1; s < NST; s++) begin
                sd_reg[s] <= sd_reg[s-1];
            end
            u_dly_reg[0] <= u;
            v_dly_reg[0] <= v;
            for (int s = 1; s < 7; s++) begin
                u_dly_reg[s] <= u_dly_reg[s-1];
                v_dly_reg[s] <= v_dly_reg[s-1];
            end
            puu_reg   <= puu_next;
            pvv_reg   <= pvv_next;
            puv_reg   <= puv_next;
            uu_reg    <= uu_next;
            vv_reg    <= vv_next;
            uv_reg    <= uv_next;
            rho2_reg  <= rho2_next;
            uu3_reg   <= uu_reg;
            vv3_reg   <= vv_reg;
            uv3_reg   <= uv_reg;
            bru_reg   <= bru_next;
            brv_reg   <= brv_next;
            prho4_reg <= prho4_next;
            pk1_reg   <= pk1_next;
            pp1uv_reg <= pp1uv_next;
            pp2uv_reg <= pp2uv_next;
            rho4_reg  <= rho4_next;
            k1t_reg   <= k1t_next;
            tp1uv_reg <= tp1uv_next;
            tp2uv_reg <= tp2uv_next;
            pp2bu_reg <= pp2bu_next;
            pp1bv_reg <= pp1bv_next;
            pk2_reg   <= pk2_next;
            du_reg    <= du_next;
            dv_reg    <= dv_next;
            k1t6_reg  <= k1t_reg;
            lr_reg    <= lr_next;
            du7_reg   <= du_reg;
            dv7_reg   <= dv_reg;
            plu_reg   <= plu_next;
            plv_reg   <= plv_next;
            du8_reg   <= du7_reg;
            dv8_reg   <= dv7_reg;
            ud_reg    <= ud_next;
            vd_reg    <= vd_next;
            pfu_reg   <= pfu_next;
            pfv_reg   <= pfv_next;
            pu_reg    <= pu_next;
            pv_reg    <= pv_next;
            resu_reg  <= resu_next;
            resv_reg  <= resv_next;
        end
    end

    assign out_valid  = vld_reg[NST-1];
    assign res_u      = resu_reg;
    assign res_v      = resv_reg;
    assign depth_zero = sd_reg[NST-1].dz;

endmodule

[hw/rtl/pinhole_reprojection_residual_top.sv]
// ============================================================================
// pinhole_reprojection_residual_top
// Pinhole camera reprojection residual with radial-tangential distortion.
// ============================================================================
// Usage:
//   Input stream (s_*): one request per point, carrying the world point, the
//   pose quaternion and translation, and the observed pixel in s_tdata.
//   Output stream (m_*): one result per request, in order; m_tdata holds the
//   saturated residuals and m_tuser flags a zero camera-frame depth, in which
//   case both residuals are zero.
//   Configuration: APB write of the distortion, focal and principal point
//   registers at byte address 4*index; the user must write them only
//   while the block is idle, which the block itself does not enforce.
//   Stages: quaternion products and entries (2), the norm divider, sign
//   stage (1), rotate/translate (3), the depth divider, clamp stage (1),
//   and twelve distortion stages.
//   Throughput: one request per cycle while no result is held; every stage
//   is a register stage with a valid bit, one quotient bit per divider stage.
//   Stall: the whole pipeline holds while a result waits on m_tready, so
//   s_tready follows that hold; nothing is lost or repeated.
//   Reset: synchronous, active low; clears all valid bits and restores the
//   register reset values (unit focal lengths, all else zero).
// ============================================================================
module pinhole_reprojection_residual_top
    import pinr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // point_x, point_y, point_z, quat_x, quat_y, quat_z, quat_w,
    // trans_x, trans_y, trans_z, observed_u, observed_v (from bit 0 up)
    input  logic [319:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // residual_u, residual_v (from bit 0 up)
    output logic [63:0]  m_tdata,
    // depth_zero
    output logic         m_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    cfg_t       cfg_reg;
    logic       adv;
    logic       wr_en;
    pose_side_t ps_in, ps_rot;
    logic       rot_valid, proj_valid, dist_valid;
    s32_t       rot [9];
    s32_t       u, v, res_u, res_v;
    tail_t      tail;
    logic       dz;

    // Advance every stage unless a result is held
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.k1 <= '0;
            cfg_reg.k2 <= '0;
            cfg_reg.p1 <= '0;
            cfg_reg.p2 <= '0;
            cfg_reg.fx <= 31'd65536;
            cfg_reg.fy <= 31'd65536;
            cfg_reg.cx <= '0;
            cfg_reg.cy <= '0;
        end else if (wr_en) begin
            case (paddr[4:2])
                REG_K1:  cfg_reg.k1 <= pwdata;
                REG_K2:  cfg_reg.k2 <= pwdata;
                REG_P1:  cfg_reg.p1 <= pwdata;
                REG_P2:  cfg_reg.p2 <= pwdata;
                REG_FX:  cfg_reg.fx <= pwdata[30:0];
                REG_FY:  cfg_reg.fy <= pwdata[30:0];
                REG_CX:  cfg_reg.cx <= pwdata;
                REG_CY:  cfg_reg.cy <= pwdata;
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb begin
        case (paddr[4:2])
            REG_K1:  prdata = cfg_reg.k1;
            REG_K2:  prdata = cfg_reg.k2;
            REG_P1:  prdata = cfg_reg.p1;
            REG_P2:  prdata = cfg_reg.p2;
            REG_FX:  prdata = {1'b0, cfg_reg.fx};
            REG_FY:  prdata = {1'b0, cfg_reg.fy};
            REG_CX:  prdata = cfg_reg.cx;
            REG_CY:  prdata = cfg_reg.cy;
            default: prdata = '0;
        endcase
    end

    // Unpack the request fields that travel beside the rotation
    always_comb begin
        ps_in.px        = s_tdata[31:0];
        ps_in.py        = s_tdata[63:32];
        ps_in.pz        = s_tdata[95:64];
        ps_in.tx        = s_tdata[191:160];
        ps_in.ty        = s_tdata[223:192];
        ps_in.tz        = s_tdata[255:224];
        ps_in.obs.obs_u = s_tdata[287:256];
        ps_in.obs.obs_v = s_tdata[319:288];
    end

    pinr_rot u_rot (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (s_tvalid),
        .qx       (s_tdata[111:96]),
        .qy       (s_tdata[127:112]),
        .qz       (s_tdata[143:128]),
        .qw       (s_tdata[159:144]),
        .side     (ps_in),
        .out_valid(rot_valid),
        .rot      (rot),
        .side_out (ps_rot)
    );

    pinr_proj u_proj (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (rot_valid),
        .rot      (rot),
        .side     (ps_rot),
        .out_valid(proj_valid),
        .u        (u),
        .v        (v),
        .tail     (tail)
    );

    pinr_dist u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (proj_valid),
        .cfg       (cfg_reg),
        .u         (u),
        .v         (v),
        .tail      (tail),
        .out_valid (dist_valid),
        .res_u     (res_u),
        .res_v     (res_v),
        .depth_zero(dz)
    );

    assign m_tvalid = dist_valid;
    assign m_tdata  = {res_v, res_u};
    assign m_tuser  = dz;

endmodule

[hw/rtl/pinr_chk.sv]
// ============================================================================
// pinr_chk
// Port-level checks of the reprojection residual block, bound to the top.
// ============================================================================
module pinr_chk (
    input logic         aclk,
    input logic         aresetn,
    input logic [319:0] s_tdata,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [63:0]  m_tdata,
    input logic         m_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic         psel,
    input logic         penable,
    input logic         pwrite,
    input logic [4:0]   paddr,
    input logic [31:0]  pwdata,
    input logic [31:0]  prdata,
    input logic         pready
);

    // No result right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Held result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Input is refused only while a result is held
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input refused without output stall");

    // Zero depth gives zero residuals
    a_dz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 64'd0)
        else $error("zero depth with nonzero residual");

    // k1 register write reads back
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && pready && paddr == 5'd0 ##1 paddr == 5'd0
        |-> prdata == $past(pwdata))
        else $error("k1 read-back mismatch");

endmodule

bind pinhole_reprojection_residual_top pinr_chk u_chk (.*);
